/* rtl/dgps_pkg.sv */
// shared types and constants of the density grid proximity store
// used by every module of the block, depends on nothing
`default_nettype none
package dgps_pkg;

    localparam int MAX_COLS   = 64;
    localparam int MAX_ROWS   = 64;
    localparam int CELL_SLOTS = 8;

    localparam int COL_W   = $clog2(MAX_COLS);
    localparam int ROW_W   = $clog2(MAX_ROWS);
    localparam int NCELLS  = MAX_COLS * MAX_ROWS;
    localparam int CELL_W  = $clog2(NCELLS);
    localparam int FILL_W  = $clog2(CELL_SLOTS);
    localparam int PT_W    = $clog2(NCELLS * CELL_SLOTS);

    localparam int COORD_W   = 24;
    localparam int Q_W       = COORD_W - 1;
    localparam int CS_W      = 20;
    localparam int TD_W      = 40;
    localparam int GRID_W    = 7;
    localparam int CFG_IDX_W = 8;
    localparam int QDEPTH    = 4;
    localparam int QPTR_W    = $clog2(QDEPTH);

    localparam logic [GRID_W-1:0] GRID_COLS_RST = 7'd64;
    localparam logic [GRID_W-1:0] GRID_ROWS_RST = 7'd64;
    localparam logic [CS_W-1:0]   CELL_SIZE_RST = 20'd2560;
    localparam logic [TD_W-1:0]   TEST_DIST_RST = 40'd6423183;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GRID_COLS = 8'd0,
        REG_GRID_ROWS = 8'd1,
        REG_CELL_SIZE = 8'd2,
        REG_TEST_DIST = 8'd3
    } t_reg_idx;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_CLOSE = 2'd1,
        ST_OFF   = 2'd2,
        ST_FULL  = 2'd3
    } t_status;

    typedef struct packed {
        logic                      func;
        logic signed [COORD_W-1:0] x_coord;
        logic signed [COORD_W-1:0] y_coord;
    } t_in_item;

    typedef struct packed {
        logic       ok;
        logic [1:0] status;
    } t_out_item;

    // classified item handed from front to back
    typedef struct packed {
        logic                      func;
        logic                      off;
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic [COL_W-1:0]          col;
        logic [ROW_W-1:0]          row;
        logic [COL_W-1:0]          c_lo;
        logic [COL_W-1:0]          c_hi;
        logic [ROW_W-1:0]          r_lo;
        logic [ROW_W-1:0]          r_hi;
    } t_job;

    typedef struct packed {
        logic clearing;
    } t_back_stat;

endpackage
`default_nettype wire

/* rtl/dgps_front.sv */
// front end: accepts points, divides by the cell size, classifies the cell
// depends on dgps_pkg
`default_nettype none
module dgps_front (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_in_valid,
    output logic                         o_in_ready,
    input  dgps_pkg::t_in_item           i_in,
    input  wire [dgps_pkg::GRID_W-1:0]   i_grid_cols,
    input  wire [dgps_pkg::GRID_W-1:0]   i_grid_rows,
    input  wire [dgps_pkg::CS_W-1:0]     i_cell_size,
    input  dgps_pkg::t_back_stat         i_stat,
    input  wire                          i_q_full,
    output logic                         o_push,
    output dgps_pkg::t_job               o_job
);
    import dgps_pkg::*;

    localparam int CNT_W = $clog2(Q_W);

    typedef enum logic [2:0] {
        F_IDLE = 3'b001,
        F_DIV  = 3'b010,
        F_PUSH = 3'b100
    } t_fstate;

    t_fstate                  r_state, n_state;
    logic [CNT_W-1:0]         r_cnt;
    logic                     r_func;
    logic signed [COORD_W-1:0] r_x, r_y;
    logic [Q_W-1:0]           r_qx, r_qy;
    logic [CS_W-1:0]          r_remx, r_remy;

    logic [CS_W:0]  remx_sh, remy_sh;
    logic           gex, gey;
    logic [Q_W-1:0] ncols, nrows;
    logic           off;

    assign o_in_ready = (r_state == F_IDLE) && !i_stat.clearing;

    // restoring division, one quotient bit per cycle for each coordinate
    assign remx_sh = {r_remx, r_qx[Q_W-1]};
    assign remy_sh = {r_remy, r_qy[Q_W-1]};
    assign gex     = remx_sh >= {1'b0, i_cell_size};
    assign gey     = remy_sh >= {1'b0, i_cell_size};

    assign ncols = (Q_W'(i_grid_cols) > Q_W'(MAX_COLS)) ? Q_W'(MAX_COLS) : Q_W'(i_grid_cols);
    assign nrows = (Q_W'(i_grid_rows) > Q_W'(MAX_ROWS)) ? Q_W'(MAX_ROWS) : Q_W'(i_grid_rows);
    assign off   = (i_cell_size == '0) || (r_qx == '0) || (r_qy == '0)
                   || (r_qx >= ncols) || (r_qy >= nrows);

    always_comb begin
        o_job.func = r_func;
        o_job.off  = off;
        o_job.x    = r_x;
        o_job.y    = r_y;
        o_job.col  = COL_W'(r_qx);
        o_job.row  = ROW_W'(r_qy);
        o_job.c_lo = COL_W'(r_qx - 1'b1);
        o_job.r_lo = ROW_W'(r_qy - 1'b1);
        o_job.c_hi = (r_qx + 1'b1 < ncols) ? COL_W'(r_qx + 1'b1) : COL_W'(r_qx);
        o_job.r_hi = (r_qy + 1'b1 < nrows) ? ROW_W'(r_qy + 1'b1) : ROW_W'(r_qy);
    end

    assign o_push = (r_state == F_PUSH) && !i_q_full;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            F_IDLE: if (i_in_valid && o_in_ready) n_state = F_DIV;
            F_DIV:  if (r_cnt == '0) n_state = F_PUSH;
            F_PUSH: if (!i_q_full) n_state = F_IDLE;
            default: n_state = F_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == F_IDLE && i_in_valid && o_in_ready) begin
            r_func <= i_in.func;
            r_x    <= i_in.x_coord;
            r_y    <= i_in.y_coord;
            // non-positive coordinates give cell 0
            r_qx   <= (i_in.x_coord > 0) ? i_in.x_coord[Q_W-1:0] : '0;
            r_qy   <= (i_in.y_coord > 0) ? i_in.y_coord[Q_W-1:0] : '0;
            r_remx <= '0;
            r_remy <= '0;
            r_cnt  <= CNT_W'(Q_W - 1);
        end else if (r_state == F_DIV) begin
            r_remx <= gex ? CS_W'(remx_sh - {1'b0, i_cell_size}) : CS_W'(remx_sh);
            r_remy <= gey ? CS_W'(remy_sh - {1'b0, i_cell_size}) : CS_W'(remy_sh);
            r_qx   <= {r_qx[Q_W-2:0], gex};
            r_qy   <= {r_qy[Q_W-2:0], gey};
            r_cnt  <= r_cnt - 1'b1;
        end
    end

endmodule
`default_nettype wire

/* rtl/dgps_queue.sv */
// short job queue between front and back
// depends on dgps_pkg
`default_nettype none
module dgps_queue (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_push,
    input  dgps_pkg::t_job   i_job,
    input  wire              i_pop,
    output dgps_pkg::t_job   o_head,
    output logic             o_full,
    output logic             o_empty
);
    import dgps_pkg::*;

    t_job              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wptr, r_rptr;
    logic [QPTR_W:0]   r_cnt;

    assign o_full  = r_cnt == (QPTR_W+1)'(QDEPTH);
    assign o_empty = r_cnt == '0;
    assign o_head  = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (i_push) r_wptr <= r_wptr + 1'b1;
            if (i_pop)  r_rptr <= r_rptr + 1'b1;
            if (i_push && !i_pop) r_cnt <= r_cnt + 1'b1;
            else if (i_pop && !i_push) r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wptr] <= i_job;
    end

endmodule
`default_nettype wire

/* rtl/dgps_back.sv */
// back end: fill counts, point store, neighbourhood scan and distance test
// depends on dgps_pkg
`default_nettype none
module dgps_back (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        i_empty,
    input  dgps_pkg::t_job             i_head,
    output logic                       o_pop,
    input  wire [dgps_pkg::TD_W-1:0]   i_test_dist_sq,
    output logic                       o_out_valid,
    input  wire                        i_out_ready,
    output dgps_pkg::t_out_item        o_out,
    output dgps_pkg::t_back_stat       o_stat
);
    import dgps_pkg::*;

    localparam int D_W  = COORD_W + 1;
    localparam int SQ_W = 2 * D_W;

    typedef enum logic [9:0] {
        B_CLR   = 10'b0000000001,
        B_IDLE  = 10'b0000000010,
        B_FRD   = 10'b0000000100,
        B_FDEC  = 10'b0000001000,
        B_SRD   = 10'b0000010000,
        B_DIFF  = 10'b0000100000,
        B_SQ    = 10'b0001000000,
        B_CMP   = 10'b0010000000,
        B_OUT   = 10'b0100000000,
        B_NEXT  = 10'b1000000000
    } t_bstate;

    t_bstate            r_state, n_state;
    t_job               r_job;
    logic [COL_W-1:0]   r_c;
    logic [ROW_W-1:0]   r_r;
    logic [FILL_W-1:0]  r_s;
    logic [CELL_W-1:0]  r_clr_addr;
    t_out_item          r_res;

    logic [FILL_W-1:0]       r_fill_mem [NCELLS];
    logic [2*COORD_W-1:0]    r_pt_mem   [NCELLS*CELL_SLOTS];
    logic [FILL_W-1:0]       r_fill_q;
    logic [2*COORD_W-1:0]    r_pt_q;

    logic [D_W-1:0]   r_adx, r_ady;
    logic [SQ_W-1:0]  r_sqx, r_sqy;

    logic [CELL_W-1:0] cell_addr;
    logic [PT_W-1:0]   pt_addr, pt_waddr;
    logic              fill_we, pt_we;
    logic [CELL_W-1:0] fill_wa;
    logic [FILL_W-1:0] fill_wd;
    logic              room, close;
    logic signed [D_W-1:0] dx, dy;
    logic [SQ_W:0]     d2;

    assign cell_addr = CELL_W'(r_r) * CELL_W'(MAX_COLS) + CELL_W'(r_c);
    assign pt_addr   = PT_W'(cell_addr) * PT_W'(CELL_SLOTS) + PT_W'(r_s);
    assign pt_waddr  = PT_W'(cell_addr) * PT_W'(CELL_SLOTS) + PT_W'(r_fill_q);
    assign room      = (FILL_W+1)'(r_fill_q) + 1'b1 < (FILL_W+1)'(CELL_SLOTS);

    assign dx    = {r_job.x[COORD_W-1], r_job.x}
                   - {r_pt_q[2*COORD_W-1], r_pt_q[2*COORD_W-1:COORD_W]};
    assign dy    = {r_job.y[COORD_W-1], r_job.y}
                   - {r_pt_q[COORD_W-1], r_pt_q[COORD_W-1:0]};
    assign d2    = (SQ_W+1)'(r_sqx) + (SQ_W+1)'(r_sqy);
    assign close = d2 <= (SQ_W+1)'(i_test_dist_sq);

    assign o_stat.clearing = r_state == B_CLR;
    assign o_pop           = (r_state == B_IDLE) && !i_empty;
    assign o_out_valid     = r_state == B_OUT;
    assign o_out           = r_res;

    always_comb begin
        fill_we = 1'b0;
        fill_wa = cell_addr;
        fill_wd = FILL_W'(r_fill_q + 1'b1);
        pt_we   = 1'b0;
        if (r_state == B_CLR) begin
            fill_we = 1'b1;
            fill_wa = r_clr_addr;
            fill_wd = '0;
        end else if (r_state == B_FDEC && r_job.func && room) begin
            fill_we = 1'b1;
            pt_we   = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fill_we) r_fill_mem[fill_wa] <= fill_wd;
        r_fill_q <= r_fill_mem[cell_addr];
    end

    always_ff @(posedge i_clk) begin
        if (pt_we) r_pt_mem[pt_waddr] <= {r_job.x, r_job.y};
        r_pt_q <= r_pt_mem[pt_addr];
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            B_CLR:  if (r_clr_addr == CELL_W'(NCELLS - 1)) n_state = B_IDLE;
            B_IDLE: begin
                if (!i_empty) n_state = i_head.off ? B_OUT : B_FRD;
            end
            B_FRD:  n_state = B_FDEC;
            B_FDEC: begin
                if (r_job.func) n_state = B_OUT;
                else if (r_fill_q == '0) n_state = B_NEXT;
                else n_state = B_SRD;
            end
            B_SRD:  n_state = B_DIFF;
            B_DIFF: n_state = B_SQ;
            B_SQ:   n_state = B_CMP;
            B_CMP: begin
                if (close) n_state = B_OUT;
                else if ((FILL_W+1)'(r_s) + 1'b1 < (FILL_W+1)'(r_fill_q)) n_state = B_SRD;
                else n_state = B_NEXT;
            end
            B_NEXT: begin
                if (r_r != r_job.r_hi || r_c != r_job.c_hi) n_state = B_FRD;
                else n_state = B_OUT;
            end
            B_OUT:  if (i_out_ready) n_state = B_IDLE;
            default: n_state = B_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= B_CLR;
            r_clr_addr <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == B_CLR) r_clr_addr <= r_clr_addr + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            B_IDLE: begin
                r_job <= i_head;
                r_s   <= '0;
                if (i_head.func) begin
                    r_c <= i_head.col;
                    r_r <= i_head.row;
                end else begin
                    r_c <= i_head.c_lo;
                    r_r <= i_head.r_lo;
                end
                r_res.ok     <= 1'b0;
                r_res.status <= ST_OFF;
            end
            B_FDEC: begin
                r_s <= '0;
                if (r_job.func) begin
                    r_res.ok     <= room;
                    r_res.status <= room ? ST_OK : ST_FULL;
                end
            end
            B_DIFF: begin
                r_adx <= dx[D_W-1] ? D_W'(-dx) : D_W'(dx);
                r_ady <= dy[D_W-1] ? D_W'(-dy) : D_W'(dy);
            end
            B_SQ: begin
                r_sqx <= r_adx * r_adx;
                r_sqy <= r_ady * r_ady;
            end
            B_CMP: begin
                r_s <= r_s + 1'b1;
                if (close) begin
                    r_res.ok     <= 1'b0;
                    r_res.status <= ST_CLOSE;
                end
            end
            B_NEXT: begin
                if (r_r != r_job.r_hi) begin
                    r_r <= r_r + 1'b1;
                end else if (r_c != r_job.c_hi) begin
                    r_c <= r_c + 1'b1;
                    r_r <= r_job.r_lo;
                end else begin
                    r_res.ok     <= 1'b1;
                    r_res.status <= ST_OK;
                end
            end
            default: ;
        endcase
    end

    a_ins_fill_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fill_we && r_state != B_CLR) |-> fill_wd != '0)
        else $error("insert writes an empty fill count");

    a_pop_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> r_state != B_IDLE)
        else $error("job popped but back end stayed idle");

    a_slot_below_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == B_CMP) |-> r_s < r_fill_q)
        else $error("slot compared beyond the cell fill");

endmodule
`default_nettype wire

/* rtl/density_grid_proximity_store.sv */
// flow: the front accepts a point, runs the 23-step cell division and pushes the job; the
// back reads and updates the fill count for an insert, sends an off-grid point straight to the
// output, and for a check scans up to nine cells, one point-memory read per stored slot
// overlap: one item in flight per stage, the front divides while the back scans
// reset: synchronous, active low; a pass that clears the fill counts follows it,
// and no item is taken until that pass ends
`default_nettype none
module density_grid_proximity_store (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_in_valid,
    output logic                             o_in_ready,
    input  dgps_pkg::t_in_item               i_in,
    output logic                             o_out_valid,
    input  wire                              i_out_ready,
    output dgps_pkg::t_out_item              o_out,
    input  wire                              i_cfg_valid,
    output logic                             o_cfg_ready,
    input  wire [dgps_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire [dgps_pkg::TD_W-1:0]         i_cfg_data
);
    import dgps_pkg::*;

    logic [GRID_W-1:0] r_grid_cols, r_grid_rows;
    logic [CS_W-1:0]   r_cell_size;
    logic [TD_W-1:0]   r_test_dist_sq;

    t_back_stat stat;
    t_job       push_job, head;
    logic       push, pop, q_full, q_empty;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_cols    <= GRID_COLS_RST;
            r_grid_rows    <= GRID_ROWS_RST;
            r_cell_size    <= CELL_SIZE_RST;
            r_test_dist_sq <= TEST_DIST_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (t_reg_idx'(i_cfg_index))
                REG_GRID_COLS: r_grid_cols    <= i_cfg_data[GRID_W-1:0];
                REG_GRID_ROWS: r_grid_rows    <= i_cfg_data[GRID_W-1:0];
                REG_CELL_SIZE: r_cell_size    <= i_cfg_data[CS_W-1:0];
                REG_TEST_DIST: r_test_dist_sq <= i_cfg_data;
                default: ;
            endcase
        end
    end

    dgps_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .i_grid_cols (r_grid_cols),
        .i_grid_rows (r_grid_rows),
        .i_cell_size (r_cell_size),
        .i_stat      (stat),
        .i_q_full    (q_full),
        .o_push      (push),
        .o_job       (push_job)
    );

    dgps_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (pop),
        .o_head  (head),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    dgps_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_empty        (q_empty),
        .i_head         (head),
        .o_pop          (pop),
        .i_test_dist_sq (r_test_dist_sq),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_out          (o_out),
        .o_stat         (stat)
    );

endmodule
`default_nettype wire
